// File: hdl/rotated_pixel_framebuffer_writer_assert.svh
// Assertion macros shared by the framebuffer writer.
// Each macro checks a property on the rising edge of clk, outside of reset.
`ifndef ROTATED_PIXEL_FRAMEBUFFER_WRITER_ASSERT_SVH
`define ROTATED_PIXEL_FRAMEBUFFER_WRITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPFW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPFW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rpfw_pkg.sv
`timescale 1ns / 1ps
package rpfw_pkg;

  // Panel geometry and framebuffer size.
  localparam int PANEL_WIDTH  = 480;
  localparam int PANEL_HEIGHT = 800;
  localparam int COL_BYTES    = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_BYTES  = PANEL_WIDTH * COL_BYTES;
  localparam int ADDR_W       = $clog2(STORE_BYTES);
  localparam int BYTE_W       = 8;

  // Panel coordinate widths, as carried in the dirty box fields.
  localparam int PX_W = 9;
  localparam int PY_W = 10;

  // Signed working width for rotation and offset.
  localparam int COORD_W = 13;

  // Configuration port.
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIFFERENTIAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 2'd3;

  // Orientation codes.
  localparam logic [1:0] ORIENT_PORTRAIT      = 2'd0;
  localparam logic [1:0] ORIENT_LANDSCAPE     = 2'd1;
  localparam logic [1:0] ORIENT_PORTRAIT_INV  = 2'd2;
  localparam logic [1:0] ORIENT_LANDSCAPE_INV = 2'd3;

  // Result kinds.
  localparam logic KIND_DIRTY = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Result queue.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 3;

  typedef enum logic [1:0] {
    CMD_PIXEL     = 2'd0,
    CMD_FRAME_END = 2'd1,
    CMD_READ      = 2'd2,
    CMD_REARM     = 2'd3
  } cmd_e;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } fsm_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [9:0]  src_col;
    logic [9:0]  src_row;
    logic        pixel_value;
    logic [15:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic       dirty_present;
    logic [8:0] dirty_left;
    logic [9:0] dirty_top;
    logic [8:0] dirty_right;
    logic [9:0] dirty_bottom;
    logic [7:0] read_byte;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        orientation;
    logic              differential_mode;
    logic signed [6:0] offset_x;
    logic signed [6:0] offset_y;
  } cfg_t;

  // One item after coordinate mapping.
  typedef struct packed {
    cmd_e              cmd;
    logic              pixel_value;
    logic              in_range;
    logic [PX_W-1:0]   px;
    logic [PY_W-1:0]   py;
    logic              read_ok;
    logic [ADDR_W-1:0] read_addr;
  } map_t;

endpackage

// File: hdl/rpfw_ram.sv
`timescale 1ns / 1ps
module rpfw_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/rpfw_xform.sv
`timescale 1ns / 1ps
module rpfw_xform
  import rpfw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  in_item_t          in_item,
  input  cfg_t              cfg,
  output logic              s1_valid,
  output map_t              s1,
  output logic [ADDR_W-1:0] mem_addr
);

  localparam logic signed [COORD_W-1:0] W_LAST = COORD_W'(PANEL_WIDTH - 1);
  localparam logic signed [COORD_W-1:0] H_LAST = COORD_W'(PANEL_HEIGHT - 1);
  localparam logic signed [COORD_W-1:0] W_LIM  = COORD_W'(PANEL_WIDTH);
  localparam logic signed [COORD_W-1:0] H_LIM  = COORD_W'(PANEL_HEIGHT);

  logic signed [COORD_W-1:0] sx, sy, rx, ry, px_s, py_s;
  logic                      in_range;
  map_t                      s1_next;

  // Rotate screen coordinates into panel coordinates, then shift.
  always_comb begin
    sx = signed'(COORD_W'(in_item.src_col));
    sy = signed'(COORD_W'(in_item.src_row));
    case (cfg.orientation)
      ORIENT_LANDSCAPE: begin
        rx = W_LAST - sy;
        ry = sx;
      end
      ORIENT_PORTRAIT_INV: begin
        rx = W_LAST - sx;
        ry = H_LAST - sy;
      end
      ORIENT_LANDSCAPE_INV: begin
        rx = sy;
        ry = H_LAST - sx;
      end
      default: begin
        rx = sx;
        ry = sy;
      end
    endcase
    px_s = rx + COORD_W'(cfg.offset_x);
    py_s = ry + COORD_W'(cfg.offset_y);
    in_range = (px_s >= 0) && (px_s < W_LIM) && (py_s >= 0) && (py_s < H_LIM);
  end

  // Fields carried to the next stage.
  always_comb begin
    s1_next.cmd         = in_item.cmd;
    s1_next.pixel_value = in_item.pixel_value;
    s1_next.in_range    = in_range;
    s1_next.px          = px_s[PX_W-1:0];
    s1_next.py          = py_s[PY_W-1:0];
    s1_next.read_ok     = 32'(in_item.read_address) < STORE_BYTES;
    s1_next.read_addr   = ADDR_W'(in_item.read_address);
  end

  // Stage register; the pipeline never stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1 <= s1_next;
    end
  end

  // Column-major byte index for a pixel, or the byte asked for by a read.
  always_comb begin
    if (s1.cmd == CMD_READ) begin
      mem_addr = s1.read_addr;
    end else begin
      mem_addr = ADDR_W'(32'(s1.px) * COL_BYTES) + ADDR_W'(s1.py >> 3);
    end
  end

endmodule

// File: hdl/rpfw_outq.sv
`timescale 1ns / 1ps
module rpfw_outq
  import rpfw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  out_item_t           push_item,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_item,
  output logic [OQ_CNT_W-1:0] count
);

  out_item_t           slots [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic                pop;

  assign out_valid = (count != '0);
  assign out_item  = slots[rd_ptr];
  assign pop       = out_valid && out_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// File: hdl/rotated_pixel_framebuffer_writer.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    in_item  (in_item_t)
// result    out        out_valid / out_ready  out_item (out_item_t)
// config    in         cfg_we                 cfg_index, cfg_data
//
// After reset the framebuffer is filled with white, one byte per cycle, for
// all 48000 bytes; in_ready stays low during that pass, config writes are taken.
// A result enters the output queue once its item has passed the map and memory
// read registers: map, memory read, then modify, write back with forwarding and push.
// One item is accepted per cycle; input stalls once queued results plus items
// in the two pipeline stages reach four, the depth of the output queue.
`include "rotated_pixel_framebuffer_writer_assert.svh"
module rotated_pixel_framebuffer_writer
  import rpfw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  fsm_e                state, state_next;
  logic                clearing;
  logic [ADDR_W-1:0]   clear_addr;
  logic                clear_last;

  cfg_t                cfg;
  logic                accept;

  logic                s1_valid;
  map_t                s1;
  logic [ADDR_W-1:0]   rd_addr;

  logic                s2_valid;
  map_t                s2;
  logic [ADDR_W-1:0]   s2_addr;

  logic [BYTE_W-1:0]   ram_rdata;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [BYTE_W-1:0]   ram_wdata;

  logic                fwd_valid;
  logic [ADDR_W-1:0]   fwd_addr;
  logic [BYTE_W-1:0]   fwd_data;

  logic [BYTE_W-1:0]   cur_byte, new_byte;
  logic [2:0]          bpos;
  logic                skip, do_write;

  logic                cycle_empty, base_sync_pending;
  logic [PX_W-1:0]     box_left, box_right;
  logic [PY_W-1:0]     box_top, box_bottom;

  logic                out_push;
  logic                box_report;
  out_item_t           res;
  logic [OQ_CNT_W-1:0] oq_count;
  logic [OQ_CNT_W:0]   occupancy;

  // Clearing pass, then normal operation.
  always_comb begin
    case (state)
      ST_CLEAR: state_next = clear_last ? ST_RUN : ST_CLEAR;
      ST_RUN:   state_next = ST_RUN;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    case (state)
      ST_CLEAR: clearing = 1'b1;
      default:  clearing = 1'b0;
    endcase
  end

  assign clear_last = (clear_addr == ADDR_W'(STORE_BYTES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clear_addr <= clear_addr + 1'b1;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIENTATION:  cfg.orientation       <= cfg_data[1:0];
        REG_DIFFERENTIAL: cfg.differential_mode <= cfg_data[0];
        REG_OFFSET_X:     cfg.offset_x          <= signed'(cfg_data);
        REG_OFFSET_Y:     cfg.offset_y          <= signed'(cfg_data);
        default:          cfg                   <= cfg;
      endcase
    end
  end

  // Take an item only when the queue has room for everything in flight.
  assign occupancy = {1'b0, oq_count} + (OQ_CNT_W + 1)'(s1_valid)
                   + (OQ_CNT_W + 1)'(s2_valid);
  assign in_ready  = !clearing && (occupancy < (OQ_CNT_W + 1)'(OQ_DEPTH));
  assign accept    = in_valid && in_ready;

  // Coordinate mapping stage.
  rpfw_xform u_xform (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_item  (in_item),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1       (s1),
    .mem_addr (rd_addr)
  );

  // Memory read stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2      <= s1;
    s2_addr <= rd_addr;
  end

  rpfw_ram #(
    .DEPTH (STORE_BYTES),
    .WIDTH (BYTE_W),
    .AW    (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // A write in the previous cycle is not yet seen by the read; forward it.
  assign cur_byte = (fwd_valid && (fwd_addr == s2_addr)) ? fwd_data : ram_rdata;
  assign bpos     = ~s2.py[2:0];
  assign skip     = cfg.differential_mode && !base_sync_pending
                  && (cur_byte[bpos] == s2.pixel_value);
  assign do_write = s2_valid && (s2.cmd == CMD_PIXEL) && s2.in_range && !skip;

  always_comb begin
    new_byte       = cur_byte;
    new_byte[bpos] = s2.pixel_value;
  end

  // Write port: fill white during the clearing pass, else pixel write-back.
  assign ram_we    = clearing || do_write;
  assign ram_waddr = clearing ? clear_addr : s2_addr;
  assign ram_wdata = clearing ? {BYTE_W{1'b1}} : new_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= do_write;
    end
    fwd_addr <= s2_addr;
    fwd_data <= new_byte;
  end

  // Dirty box and sync flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_empty       <= 1'b1;
      base_sync_pending <= 1'b1;
      box_left          <= '0;
      box_right         <= '0;
      box_top           <= '0;
      box_bottom        <= '0;
    end else if (s2_valid) begin
      case (s2.cmd)
        CMD_PIXEL: begin
          if (do_write) begin
            cycle_empty <= 1'b0;
            if (cycle_empty || (s2.px < box_left)) begin
              box_left <= s2.px;
            end
            if (cycle_empty || (s2.px > box_right)) begin
              box_right <= s2.px;
            end
            if (cycle_empty || (s2.py < box_top)) begin
              box_top <= s2.py;
            end
            if (cycle_empty || (s2.py > box_bottom)) begin
              box_bottom <= s2.py;
            end
          end
        end
        CMD_FRAME_END: begin
          if (!cycle_empty) begin
            cycle_empty       <= 1'b1;
            base_sync_pending <= 1'b0;
          end
        end
        CMD_REARM: begin
          base_sync_pending <= 1'b1;
        end
        default: begin
          cycle_empty <= cycle_empty;
        end
      endcase
    end
  end

  // Result item for a frame end or a read.
  assign out_push = s2_valid && ((s2.cmd == CMD_FRAME_END) || (s2.cmd == CMD_READ));

  always_comb begin
    res = '0;
    if (s2.cmd == CMD_READ) begin
      res.result_kind = KIND_READ;
      res.read_byte   = s2.read_ok ? cur_byte : '0;
    end else begin
      res.result_kind = KIND_DIRTY;
      if (!cycle_empty) begin
        res.dirty_present = 1'b1;
        res.dirty_left    = box_left;
        res.dirty_top     = box_top;
        res.dirty_right   = box_right;
        res.dirty_bottom  = box_bottom;
      end
    end
  end

  rpfw_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (out_push),
    .push_item (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .count     (oq_count)
  );

  // A frame end that finds a nonempty box reports it.
  assign box_report = s2_valid && (s2.cmd == CMD_FRAME_END) && !cycle_empty;

  // The admission check must keep the queue from overflowing.
  `RPFW_ASSERT_NOW(a_queue_room, out_push, oq_count < OQ_CNT_W'(OQ_DEPTH), "result queue overflow")
  // No item may be in the pipeline while the memory is being cleared.
  `RPFW_ASSERT_NOW(a_clear_idle, clearing, !s1_valid && !s2_valid, "item in flight during clear")
  // A frame end that reports a box starts a new cycle and drops base sync.
  `RPFW_ASSERT_NEXT(a_frame_end, box_report, cycle_empty && !base_sync_pending, "no restart")

endmodule
